// ===== hw/rtl/uv_sphere_mesh_generator_defines.svh =====
// Assertion macros used by uvs_emit.
`ifndef UV_SPHERE_MESH_GENERATOR_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/uvs_pkg.sv =====
package uvs_pkg;

  localparam int IW = 13;
  localparam int PW = 17;
  localparam int NW = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam int CORDIC_MAX_ITER = 24;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS = 8;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [NW-1:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [PW-1:0] POS_LIMIT = 17'sd65535;

  typedef enum logic [1:0] {
    CMD_GRID  = 2'd0,
    CMD_NORTH = 2'd1,
    CMD_SOUTH = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_RING_COUNT  = 2'd0,
    REG_SLICE_COUNT = 2'd1,
    REG_RADIUS      = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_GRID  = 2'd0,
    CLS_NORTH = 2'd1,
    CLS_SOUTH = 2'd2,
    CLS_BAD   = 2'd3
  } cls_t;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  typedef struct packed {
    logic [IW-1:0] a;
    logic [IW-1:0] b;
    logic [IW-1:0] c;
  } tri_t;

  typedef struct packed {
    cls_t       cls;
    logic [1:0] ntri;
    tri_t [2:0] tris;
  } side_t;

  typedef struct packed {
    side_t                       side;
    logic signed [2:0][PW-1:0]   pos;
    logic signed [2:0][NW-1:0]   nrm;
  } rec_t;

  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:  atan_turn = 32'h20000000;
      1:  atan_turn = 32'h12E4051E;
      2:  atan_turn = 32'h09FB385B;
      3:  atan_turn = 32'h051111D4;
      4:  atan_turn = 32'h028B0D43;
      5:  atan_turn = 32'h0145D7E1;
      6:  atan_turn = 32'h00A2F61E;
      7:  atan_turn = 32'h00517C55;
      8:  atan_turn = 32'h0028BE53;
      9:  atan_turn = 32'h00145F2F;
      10: atan_turn = 32'h000A2F98;
      11: atan_turn = 32'h000517CC;
      12: atan_turn = 32'h00028BE6;
      13: atan_turn = 32'h000145F3;
      14: atan_turn = 32'h0000A2FA;
      15: atan_turn = 32'h0000517D;
      16: atan_turn = 32'h000028BE;
      17: atan_turn = 32'h0000145F;
      18: atan_turn = 32'h00000A30;
      19: atan_turn = 32'h00000518;
      20: atan_turn = 32'h0000028C;
      21: atan_turn = 32'h00000146;
      22: atan_turn = 32'h000000A3;
      23: atan_turn = 32'h00000051;
      default: atan_turn = 32'h0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/uvs_if.sv =====
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] ring_index;
  logic [5:0] slice_index;
  modport source (output valid, cmd, ring_index, slice_index, input ready);
  modport sink (input valid, cmd, ring_index, slice_index, output ready);
endinterface

interface uvs_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [uvs_pkg::PW-1:0]    pos_x;
  logic signed [uvs_pkg::PW-1:0]    pos_y;
  logic signed [uvs_pkg::PW-1:0]    pos_z;
  logic signed [uvs_pkg::NW-1:0]    norm_x;
  logic signed [uvs_pkg::NW-1:0]    norm_y;
  logic signed [uvs_pkg::NW-1:0]    norm_z;
  logic [uvs_pkg::IW-1:0]           first_index;
  logic [uvs_pkg::IW-1:0]           second_index;
  logic [uvs_pkg::IW-1:0]           third_index;
  logic                             bad_point;
  logic                             last;
  modport source (output valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  first_index, second_index, third_index, bad_point, last,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                first_index, second_index, third_index, bad_point, last,
                output ready);
endinterface

interface uvs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [uvs_pkg::CFG_IW-1:0]   index;
  logic [uvs_pkg::CFG_DW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/uvs_cordic.sv =====
module uvs_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int N = (ITERATIONS < uvs_pkg::CORDIC_MAX_ITER) ? ITERATIONS
                                                             : uvs_pkg::CORDIC_MAX_ITER;

  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [33:0] z_r [0:N];
  logic               f_r [0:N];
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  logic [31:0]        turn_sum;
  logic [31:0]        p_adj;
  logic               flip;
  logic signed [33:0] xn;
  logic signed [33:0] yn;

  always_comb begin
    turn_sum = phase_i + 32'h4000_0000;
    flip = turn_sum[31];
    p_adj = flip ? (phase_i - 32'h8000_0000) : phase_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= uvs_pkg::CORDIC_START;
      y_r[0] <= '0;
      z_r[0] <= {{2{p_adj[31]}}, p_adj};
      f_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [33:0] ang;
    assign ang = {2'b00, uvs_pkg::atan_turn(i)};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ang;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ang;
        end
        f_r[i+1] <= f_r[i];
      end
    end
  end

  assign xn = f_r[N] ? -x_r[N] : x_r[N];
  assign yn = f_r[N] ? -y_r[N] : y_r[N];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= xn[31:0];
      sin_r <= yn[31:0];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== hw/rtl/uvs_emit.sv =====
`include "uv_sphere_mesh_generator_defines.svh"

module uvs_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rec_valid_i,
  input  uvs_pkg::rec_t   rec_i,
  output logic            rec_take_o,
  uvs_out_if.source       out_ch
);

  uvs_pkg::rec_t rec_r;
  logic          busy_r;
  logic [1:0]    idx_r;
  logic [1:0]    ti;
  logic          last_beat;
  logic          is_tri;
  uvs_pkg::tri_t cur_tri;

  assign last_beat = (idx_r == rec_r.side.ntri);
  assign rec_take_o = !busy_r || (out_ch.ready && last_beat);
  assign ti = idx_r - 2'd1;
  assign is_tri = (idx_r != 2'd0);
  assign cur_tri = rec_r.side.tris[ti];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else if (rec_take_o) begin
      busy_r <= rec_valid_i;
      idx_r <= '0;
    end else if (out_ch.ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take_o) begin
      rec_r <= rec_i;
    end
  end

  always_comb begin
    out_ch.valid = busy_r;
    out_ch.kind = is_tri ? uvs_pkg::KIND_TRIANGLE : uvs_pkg::KIND_VERTEX;
    out_ch.pos_x = is_tri ? '0 : rec_r.pos[0];
    out_ch.pos_y = is_tri ? '0 : rec_r.pos[1];
    out_ch.pos_z = is_tri ? '0 : rec_r.pos[2];
    out_ch.norm_x = is_tri ? '0 : rec_r.nrm[0];
    out_ch.norm_y = is_tri ? '0 : rec_r.nrm[1];
    out_ch.norm_z = is_tri ? '0 : rec_r.nrm[2];
    out_ch.first_index = is_tri ? cur_tri.a : '0;
    out_ch.second_index = is_tri ? cur_tri.b : '0;
    out_ch.third_index = is_tri ? cur_tri.c : '0;
    out_ch.bad_point = !is_tri && (rec_r.side.cls == uvs_pkg::CLS_BAD);
    out_ch.last = last_beat;
  end

  `UVS_ASSERT_IMP(a_bad_is_last, clk, rst_n, busy_r && out_ch.bad_point, out_ch.last,
                  "error beat must be the last beat")
  `UVS_ASSERT_IMP(a_tri_not_bad, clk, rst_n, busy_r && is_tri,
                  !out_ch.bad_point && (idx_r <= rec_r.side.ntri),
                  "triangle beat out of range")
  `UVS_ASSERT_NXT(a_hold_mid, clk, rst_n, busy_r && out_ch.ready && !last_beat,
                  busy_r && (idx_r == $past(idx_r) + 2'd1), "beat sequence broken")

endmodule

// ===== hw/rtl/uv_sphere_mesh_generator.sv =====
// Channel  Dir  Carries
// in_ch    in   cmd, ring_index, slice_index
// out_ch   out  one vertex beat, then up to three triangle beats, last on the final beat
// cfg_ch   in   register index and write data, always ready
// A new item enters every cycle unless a stall at out_ch holds the pipeline.
// A grid point produces 2 to 4 beats on out_ch, so the output port sets the sustained rate.
// Reset is synchronous and active low, restoring ring and slice counts of 10 and radius 256.
// A stall at out_ch freezes the whole pipeline once its last stage holds an item;
// no item is lost or repeated.
module uv_sphere_mesh_generator #(
  parameter int MAX_RINGS = 64,
  parameter int MAX_SLICES = 64,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  uvs_in_if.sink     in_ch,
  uvs_out_if.source  out_ch,
  uvs_cfg_if.sink    cfg_ch
);

  localparam int IW = uvs_pkg::IW;
  localparam int RW = $clog2(MAX_RINGS + 2);
  localparam int SW = $clog2(MAX_SLICES + 1);
  localparam int DVW = ((RW > SW) ? RW : SW) + 1;
  localparam int NIT = (TRIG_ITERATIONS < uvs_pkg::CORDIC_MAX_ITER) ? TRIG_ITERATIONS
                                                                    : uvs_pkg::CORDIC_MAX_ITER;
  localparam int ST_DIV = uvs_pkg::DIV_STAGES;
  localparam int ST_COR = ST_DIV + NIT + 2;
  localparam int ST_M1 = ST_COR + 1;
  localparam int ST_M2 = ST_COR + 2;
  localparam int ST_M3 = ST_COR + 3;

  logic [6:0]  ring_cfg_r;
  logic [6:0]  slice_cfg_r;
  logic [15:0] radius_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_cfg_r <= 7'd10;
      slice_cfg_r <= 7'd10;
      radius_r <= 16'd256;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        uvs_pkg::REG_RING_COUNT:  ring_cfg_r <= cfg_ch.data[6:0];
        uvs_pkg::REG_SLICE_COUNT: slice_cfg_r <= cfg_ch.data[6:0];
        uvs_pkg::REG_RADIUS:      radius_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic [RW-1:0] rings;
  logic [SW-1:0] slices;
  logic [RW-1:0] div_p;

  always_comb begin
    if (ring_cfg_r == 7'd0) begin
      rings = RW'(1);
    end else if (ring_cfg_r > MAX_RINGS) begin
      rings = RW'(MAX_RINGS);
    end else begin
      rings = RW'(ring_cfg_r);
    end
    if (slice_cfg_r < 7'd3) begin
      slices = SW'(3);
    end else if (slice_cfg_r > MAX_SLICES) begin
      slices = SW'(MAX_SLICES);
    end else begin
      slices = SW'(slice_cfg_r);
    end
    div_p = rings + RW'(1);
  end

  logic            val_r [0:ST_M3];
  uvs_pkg::side_t  side_r [0:ST_M3];
  logic            adv;
  logic            rec_take;

  assign adv = !val_r[ST_M3] || rec_take;
  assign in_ch.ready = adv;

  uvs_pkg::side_t side0;
  logic [IW-1:0]  ring_w, slice_w, rings_w, slices_w;
  logic [IW-1:0]  tl, tr, north, south, tls, trs;
  logic           grid_ok, first_ring, last_ring;
  uvs_pkg::tri_t  t_north, t_south, t_band1, t_band2;

  always_comb begin
    ring_w = IW'(in_ch.ring_index);
    slice_w = IW'(in_ch.slice_index);
    rings_w = IW'(rings);
    slices_w = IW'(slices);
    tl = ring_w * slices_w + slice_w;
    tr = (in_ch.slice_index == slices - SW'(1)) ? ring_w * slices_w : tl + IW'(1);
    north = rings_w * slices_w;
    south = north + IW'(1);
    tls = tl + slices_w;
    trs = tr + slices_w;
    t_north = '{a: tr, b: tl, c: north};
    t_south = '{a: tl, b: tr, c: south};
    t_band1 = '{a: tl, b: tr, c: tls};
    t_band2 = '{a: tls, b: tr, c: trs};
    first_ring = (in_ch.ring_index == 6'd0);
    last_ring = (in_ch.ring_index == rings - RW'(1));
    grid_ok = (in_ch.cmd == uvs_pkg::CMD_GRID) && (in_ch.ring_index < rings) &&
              (in_ch.slice_index < slices);
    side0 = '0;
    case (in_ch.cmd)
      uvs_pkg::CMD_NORTH: side0.cls = uvs_pkg::CLS_NORTH;
      uvs_pkg::CMD_SOUTH: side0.cls = uvs_pkg::CLS_SOUTH;
      default: side0.cls = grid_ok ? uvs_pkg::CLS_GRID : uvs_pkg::CLS_BAD;
    endcase
    if (side0.cls == uvs_pkg::CLS_GRID) begin
      if (first_ring && last_ring) begin
        side0.ntri = 2'd2;
        side0.tris[0] = t_north;
        side0.tris[1] = t_south;
      end else if (first_ring) begin
        side0.ntri = 2'd3;
        side0.tris[0] = t_north;
        side0.tris[1] = t_band1;
        side0.tris[2] = t_band2;
      end else if (last_ring) begin
        side0.ntri = 2'd1;
        side0.tris[0] = t_south;
      end else begin
        side0.ntri = 2'd2;
        side0.tris[0] = t_band1;
        side0.tris[1] = t_band2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ST_M3; i++) begin
        val_r[i] <= 1'b0;
      end
    end else if (adv) begin
      val_r[0] <= in_ch.valid;
      for (int i = 1; i <= ST_M3; i++) begin
        val_r[i] <= val_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0;
      for (int i = 1; i <= ST_M3; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  logic [DVW-1:0] remp_r [0:ST_DIV];
  logic [DVW-1:0] rema_r [0:ST_DIV];
  logic [31:0]    qp_r [0:ST_DIV];
  logic [31:0]    qa_r [0:ST_DIV];

  always_ff @(posedge clk) begin
    if (adv) begin
      remp_r[0] <= DVW'(in_ch.ring_index) + DVW'(1);
      rema_r[0] <= DVW'(in_ch.slice_index);
      qp_r[0] <= '0;
      qa_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= ST_DIV; j++) begin : g_div
    logic [DVW-1:0] rp, ra;
    logic [31:0]    qp, qa;
    always_comb begin
      rp = remp_r[j-1];
      ra = rema_r[j-1];
      qp = qp_r[j-1];
      qa = qa_r[j-1];
      for (int b = 0; b < uvs_pkg::DIV_BITS; b++) begin
        rp = {rp[DVW-2:0], 1'b0};
        ra = {ra[DVW-2:0], 1'b0};
        qp = {qp[30:0], 1'b0};
        qa = {qa[30:0], 1'b0};
        if (rp >= div_p) begin
          rp = rp - DVW'(div_p);
          qp[0] = 1'b1;
        end
        if (ra >= slices) begin
          ra = ra - DVW'(slices);
          qa[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        remp_r[j] <= rp;
        rema_r[j] <= ra;
        qp_r[j] <= qp;
        qa_r[j] <= qa;
      end
    end
  end

  logic signed [31:0] cos_t, sin_t, cos_a, sin_a;

  uvs_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_cordic_polar (
    .clk     (clk),
    .en      (adv),
    .phase_i ({1'b0, qp_r[ST_DIV][31:1]}),
    .cos_o   (cos_t),
    .sin_o   (sin_t)
  );

  uvs_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_cordic_azim (
    .clk     (clk),
    .en      (adv),
    .phase_i (qa_r[ST_DIV]),
    .cos_o   (cos_a),
    .sin_o   (sin_a)
  );

  logic signed [63:0] prod_x, prod_y;
  logic signed [31:0] n30_r [0:2];

  assign prod_x = sin_t * sin_a;
  assign prod_y = sin_t * cos_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      n30_r[0] <= prod_x[61:30];
      n30_r[1] <= prod_y[61:30];
      n30_r[2] <= cos_t;
    end
  end

  logic signed [48:0]          pprod_r [0:2];
  logic signed [uvs_pkg::NW-1:0] nrm2_r [0:2];
  logic signed [uvs_pkg::PW-1:0] pos_r [0:2];
  logic signed [uvs_pkg::NW-1:0] nrm3_r [0:2];
  logic signed [16:0]          rad_s;

  assign rad_s = $signed({1'b0, radius_r});

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [32:0] nsum;
    logic signed [16:0] nsh;
    logic signed [uvs_pkg::NW-1:0] nsat;
    logic signed [48:0] pp;
    logic signed [49:0] psum;
    logic signed [19:0] psh;
    logic signed [uvs_pkg::PW-1:0] psat;

    always_comb begin
      nsum = {n30_r[k][31], n30_r[k]} + 33'sd32768;
      nsh = nsum[32:16];
      if (nsh > 17'sd16384) begin
        nsat = uvs_pkg::ONE_Q14;
      end else if (nsh < -17'sd16384) begin
        nsat = -uvs_pkg::ONE_Q14;
      end else begin
        nsat = nsh[15:0];
      end
      pp = rad_s * n30_r[k];
      psum = {pprod_r[k][48], pprod_r[k]} + 50'sd536870912;
      psh = psum[49:30];
      if (psh > 20'sd65535) begin
        psat = uvs_pkg::POS_LIMIT;
      end else if (psh < -20'sd65535) begin
        psat = -uvs_pkg::POS_LIMIT;
      end else begin
        psat = psh[16:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pprod_r[k] <= pp;
        nrm2_r[k] <= nsat;
        pos_r[k] <= psat;
        nrm3_r[k] <= nrm2_r[k];
      end
    end
  end

  uvs_pkg::rec_t rec;

  always_comb begin
    rec = '0;
    rec.side = side_r[ST_M3];
    case (side_r[ST_M3].cls)
      uvs_pkg::CLS_GRID: begin
        for (int k = 0; k < 3; k++) begin
          rec.pos[k] = pos_r[k];
          rec.nrm[k] = nrm3_r[k];
        end
      end
      uvs_pkg::CLS_NORTH: begin
        rec.pos[2] = rad_s;
        rec.nrm[2] = uvs_pkg::ONE_Q14;
      end
      uvs_pkg::CLS_SOUTH: begin
        rec.pos[2] = -rad_s;
        rec.nrm[2] = -uvs_pkg::ONE_Q14;
      end
      default: ;
    endcase
  end

  uvs_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_valid_i (val_r[ST_M3]),
    .rec_i       (rec),
    .rec_take_o  (rec_take),
    .out_ch      (out_ch)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIG_STEPS = 16;
  localparam int RING_LIMIT = 64;
  localparam int SLICE_LIMIT = 64;
  localparam int PW = uvs_pkg::PW;
  localparam int NW = uvs_pkg::NW;
  localparam int IW = uvs_pkg::IW;
  localparam int CFG_DW = uvs_pkg::CFG_DW;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = TRIG_STEPS + 24;

  localparam longint ATAN_TURN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef enum int {CHK_MODEL, CHK_NORTH, CHK_SOUTH, CHK_BAD} chk_t;

  typedef struct {
    logic                   kind;
    logic signed [PW-1:0]   px, py, pz;
    logic signed [NW-1:0]   nx, ny, nz;
    logic [IW-1:0]          i0, i1, i2;
    logic                   bad;
    logic                   last;
  } mesh_beat_t;

  typedef struct {
    logic [1:0] cmd;
    int         ring;
    int         slice;
    chk_t       chk;
  } point_row_t;

  typedef struct {
    int ring;
    int slice;
    int rad;
    int items;
    int tx_pct;
    int rx_pct;
    int hold;
  } sweep_t;

  logic clk;
  logic rst_n;

  uvs_in_if  in_ch();
  uvs_out_if out_ch();
  uvs_cfg_if cfg_ch();

  uv_sphere_mesh_generator #(
    .MAX_RINGS(RING_LIMIT),
    .MAX_SLICES(SLICE_LIMIT),
    .TRIG_ITERATIONS(TRIG_STEPS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  mesh_beat_t expected_q[$];
  int         ring_reg, slice_reg, radius_reg;
  int         tx_pct, rx_pct;
  int         hold_cycles;
  int         errors, points_sent, beats_seen, cfg_writes;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                  output longint s);
    logic [31:0] p;
    logic [31:0] q;
    logic        flip;
    longint      x, y, z, dx, dy;
    p = phase;
    q = p + 32'h40000000;
    flip = q[31];
    if (flip) p = p - 32'h80000000;
    z = longint'($signed(p));
    x = 652032874;
    y = 0;
    for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic mesh_beat_t blank_beat();
    mesh_beat_t b;
    b.kind = uvs_pkg::KIND_VERTEX;
    b.px = '0; b.py = '0; b.pz = '0;
    b.nx = '0; b.ny = '0; b.nz = '0;
    b.i0 = '0; b.i1 = '0; b.i2 = '0;
    b.bad = 1'b0;
    b.last = 1'b0;
    return b;
  endfunction

  function automatic mesh_beat_t tri_beat(input longint a, input longint b, input longint c);
    mesh_beat_t t;
    t = blank_beat();
    t.kind = uvs_pkg::KIND_TRIANGLE;
    t.i0 = a[IW-1:0];
    t.i1 = b[IW-1:0];
    t.i2 = c[IW-1:0];
    return t;
  endfunction

  function automatic void predict_mesh(input logic [1:0] cmd, input int ring, input int slice);
    mesh_beat_t b;
    mesh_beat_t beats[$];
    longint     rr, ss, rad, ct, st, ca, sa, tl, tr, north;
    longint     n30[3];
    longint     pv[3];
    longint     nv[3];
    logic [63:0] t64, a64;
    rr = clamp(ring_reg, 1, RING_LIMIT);
    ss = clamp(slice_reg, 3, SLICE_LIMIT);
    rad = radius_reg;
    b = blank_beat();
    b.last = 1'b1;
    if (cmd == uvs_pkg::CMD_NORTH || cmd == uvs_pkg::CMD_SOUTH) begin
      b.pz = PW'((cmd == uvs_pkg::CMD_NORTH) ? rad : -rad);
      b.nz = NW'((cmd == uvs_pkg::CMD_NORTH) ? 16384 : -16384);
      expected_q.push_back(b);
      return;
    end
    if (cmd == CMD_UNUSED || ring >= rr || slice >= ss) begin
      b.bad = 1'b1;
      expected_q.push_back(b);
      return;
    end
    t64 = (64'(ring + 1) << 31) / 64'(rr + 1);
    a64 = (64'(slice) << 32) / 64'(ss);
    sin_cos(t64[31:0], ct, st);
    sin_cos(a64[31:0], ca, sa);
    n30[0] = (st * sa) >>> 30;
    n30[1] = (st * ca) >>> 30;
    n30[2] = ct;
    for (int j = 0; j < 3; j++) begin
      nv[j] = clamp((n30[j] + 32768) >>> 16, -16384, 16384);
      pv[j] = clamp((rad * n30[j] + (64'sd1 <<< 29)) >>> 30, -65535, 65535);
    end
    b.last = 1'b0;
    b.px = PW'(pv[0]); b.py = PW'(pv[1]); b.pz = PW'(pv[2]);
    b.nx = NW'(nv[0]); b.ny = NW'(nv[1]); b.nz = NW'(nv[2]);
    beats.push_back(b);
    north = rr * ss;
    tl = ring * ss + slice;
    tr = (slice == ss - 1) ? ring * ss : tl + 1;
    if (ring == 0) beats.push_back(tri_beat(tr, tl, north));
    if (ring == rr - 1) begin
      beats.push_back(tri_beat(tl, tr, north + 1));
    end else begin
      beats.push_back(tri_beat(tl, tr, tl + ss));
      beats.push_back(tri_beat(tl + ss, tr, tr + ss));
    end
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[k]) expected_q.push_back(beats[k]);
  endfunction

  function automatic void check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    mesh_beat_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_pct);
      end
      if (out_ch.valid && out_ch.ready) begin
        beats_seen++;
        if (expected_q.size() == 0) begin
          $error("result beat arrived with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("kind", longint'(e.kind), longint'(out_ch.kind));
          check_field("pos_x", longint'(e.px), longint'(out_ch.pos_x));
          check_field("pos_y", longint'(e.py), longint'(out_ch.pos_y));
          check_field("pos_z", longint'(e.pz), longint'(out_ch.pos_z));
          check_field("norm_x", longint'(e.nx), longint'(out_ch.norm_x));
          check_field("norm_y", longint'(e.ny), longint'(out_ch.norm_y));
          check_field("norm_z", longint'(e.nz), longint'(out_ch.norm_z));
          check_field("first_index", longint'(e.i0), longint'(out_ch.first_index));
          check_field("second_index", longint'(e.i1), longint'(out_ch.second_index));
          check_field("third_index", longint'(e.i2), longint'(out_ch.third_index));
          check_field("bad_point", longint'(e.bad), longint'(out_ch.bad_point));
          check_field("last", longint'(e.last), longint'(out_ch.last));
        end
      end
    end
  end

  task automatic send_point(input logic [1:0] cmd, input int ring, input int slice,
                            input chk_t chk);
    mesh_beat_t b;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.ring_index <= ring[5:0];
    in_ch.slice_index <= slice[5:0];
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
    b = blank_beat();
    b.last = 1'b1;
    case (chk)
      CHK_NORTH: begin
        b.pz = 17'sd256;
        b.nz = 16'sd16384;
        expected_q.push_back(b);
      end
      CHK_SOUTH: begin
        b.pz = -17'sd256;
        b.nz = -16'sd16384;
        expected_q.push_back(b);
      end
      CHK_BAD: begin
        b.bad = 1'b1;
        expected_q.push_back(b);
      end
      default: predict_mesh(cmd, ring, slice);
    endcase
  endtask

  task automatic write_reg(input uvs_pkg::reg_idx_t idx, input int value);
    logic [CFG_DW-1:0] d;
    d = value[CFG_DW-1:0];
    if (idx != uvs_pkg::REG_RADIUS) d[CFG_DW-1:7] = (CFG_DW-7)'($urandom());
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
    case (idx)
      uvs_pkg::REG_RING_COUNT:  ring_reg = int'(d[6:0]);
      uvs_pkg::REG_SLICE_COUNT: slice_reg = int'(d[6:0]);
      default:                  radius_reg = int'(d);
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_point();
    int rr, ss, roll;
    rr = int'(clamp(ring_reg, 1, RING_LIMIT));
    ss = int'(clamp(slice_reg, 3, SLICE_LIMIT));
    roll = $urandom_range(0, 99);
    if (roll < 78) begin
      send_point(uvs_pkg::CMD_GRID, $urandom_range(0, rr - 1), $urandom_range(0, ss - 1),
                 CHK_MODEL);
    end else if (roll < 88) begin
      send_point(uvs_pkg::CMD_GRID, $urandom_range(0, 63), $urandom_range(0, 63), CHK_MODEL);
    end else if (roll < 93) begin
      send_point(uvs_pkg::CMD_NORTH, $urandom_range(0, 63), $urandom_range(0, 63), CHK_MODEL);
    end else if (roll < 97) begin
      send_point(uvs_pkg::CMD_SOUTH, $urandom_range(0, 63), $urandom_range(0, 63), CHK_MODEL);
    end else begin
      send_point(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), CHK_MODEL);
    end
  endtask

  point_row_t directed_rows[] = '{
    '{uvs_pkg::CMD_NORTH,  0,  0, CHK_NORTH},
    '{uvs_pkg::CMD_SOUTH, 63, 63, CHK_SOUTH},
    '{CMD_UNUSED,          0,  0, CHK_BAD},
    '{CMD_UNUSED,         63, 63, CHK_BAD},
    '{uvs_pkg::CMD_GRID,  10,  0, CHK_BAD},
    '{uvs_pkg::CMD_GRID,   0, 10, CHK_BAD},
    '{uvs_pkg::CMD_GRID,  63, 63, CHK_BAD},
    '{uvs_pkg::CMD_GRID,   0,  0, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   0,  9, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   9,  0, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   9,  9, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   4,  9, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   5,  3, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   2,  7, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   7,  2, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   1,  5, CHK_MODEL},
    '{uvs_pkg::CMD_GRID,   8,  8, CHK_MODEL},
    '{uvs_pkg::CMD_NORTH, 21, 42, CHK_NORTH},
    '{uvs_pkg::CMD_SOUTH, 42, 21, CHK_SOUTH}
  };

  sweep_t sweeps[] = '{
    '{  1,   3, 65535, 30, 19, 73,   0},
    '{ 64,  64,     1, 40, 19, 73, 250},
    '{  0, 127,     0, 30, 73, 19,   0},
    '{127,   0,   300, 40, 73, 19,   0},
    '{  3,   5,   777, 40, 73, 19,   0},
    '{ 10,  10,   256, 45,  0,  0,   0},
    '{  7,  64, 65535, 45,  0,  0, 120}
  };

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = uvs_pkg::CMD_GRID;
    in_ch.ring_index = '0;
    in_ch.slice_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = uvs_pkg::REG_RING_COUNT;
    cfg_ch.data = '0;
    hold_cycles = 0;
    errors = 0;
    points_sent = 0;
    beats_seen = 0;
    cfg_writes = 0;
    ring_reg = 10;
    slice_reg = 10;
    radius_reg = 256;
    tx_pct = 19;
    rx_pct = 73;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_point(directed_rows[i].cmd, directed_rows[i].ring, directed_rows[i].slice,
                 directed_rows[i].chk);
    drain();

    foreach (sweeps[p]) begin
      write_reg(uvs_pkg::REG_RING_COUNT, sweeps[p].ring);
      write_reg(uvs_pkg::REG_SLICE_COUNT, sweeps[p].slice);
      write_reg(uvs_pkg::REG_RADIUS, p == 4 ? $urandom_range(1, 65535) : sweeps[p].rad);
      tx_pct = sweeps[p].tx_pct;
      rx_pct = sweeps[p].rx_pct;
      @(posedge clk);
      hold_cycles = sweeps[p].hold;
      repeat (sweeps[p].items) random_point();
      drain();
    end

    $display("Covered %0d points and %0d result beats over %0d register writes,",
             points_sent, beats_seen, cfg_writes);
    $display("including clamped ring and slice counts, zero and full-scale radius.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
